@@ hdl/mqsb_pkg.sv @@
package mqsb_pkg;

  // fixed field widths of the channels
  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned QID_W    = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ_RD,
    S_DEQ_WB
  } state_e;

endpackage

@@ hdl/mqsb_if.sv @@
// request channel: one operation word
interface mqsb_req_if;
  import mqsb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [QID_W-1:0]         queue_id;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, func, queue_id, data_in, input ready);
  modport sink (input valid, func, queue_id, data_in, output ready);
endinterface

// response channel: one result word
interface mqsb_rsp_if;
  import mqsb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, data_out, status, input ready);
  modport sink (input valid, data_out, status, output ready);
endinterface

@@ hdl/mqsb_ram.sv @@
module mqsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port, registered read that holds without a read enable
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/multi_queue_shared_buffer_top.sv @@
// Several FIFO queues sharing one slot store, kept as linked lists with a
// common free list.
// req_i carries one operation word: func (enqueue or dequeue), queue_id and
// data_in. rsp_o returns exactly one word per request: data_out (dequeued
// value, zero otherwise) and status (ok, overflow, underflow).
// A request is taken when the sequencer is idle. The result of an enqueue,
// overflow or underflow is registered in the state entered on acceptance
// (S_ENQ or S_DEQ_RD), that of a dequeue that returns a word in S_DEQ_WB,
// after S_DEQ_RD. The sequencer then goes back to idle, so a new request
// is taken only once the last one is through. The registered reads of the
// queue table and link memory must complete before list pointers update.
// Slot links, slot data and the per-queue head and tail pointers live in
// synchronous RAMs; the free-list head and a fill count are in flops.
// Reset clears the free-list head, the fill count and the queue valid bits
// at once; no clearing pass runs, never allocated slots are recognized by the
// fill count, so requests are taken right after reset.
// A finished result waits in the output register; while it is not taken,
// the next request is still accepted and its work holds in its last cycle
// until the output register frees up.
module multi_queue_shared_buffer_top #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned QUEUES     = 4,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mqsb_req_if.sink   req_i,
  mqsb_rsp_if.source rsp_o
);
  import mqsb_pkg::*;

  localparam int unsigned IW  = $clog2(SLOTS);
  localparam int unsigned PW  = $clog2(SLOTS + 1);
  localparam int unsigned QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned SW  = (DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  // queue number wraps when fewer queues than codes exist
  function automatic logic [QW-1:0] queue_wrap(input logic [QID_W-1:0] id);
    logic [QW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << QID_W); i++) begin
      if (id == QID_W'(i)) begin
        r = QW'(i % QUEUES);
      end
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [QW-1:0]     q_q, q_d;
  logic [SW-1:0]     data_q, data_d;
  logic              qv_q, qv_d;
  logic [PW-1:0]     free_head_q, free_head_d;
  logic [PW-1:0]     fill_q, fill_d;
  logic [QUEUES-1:0] qvalid_q, qvalid_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  // memory ports
  logic              qt_we, qt_re;
  logic [QW-1:0]     qt_waddr, qt_raddr;
  logic [2*PW-1:0]   qt_wdata, qt_rdata;
  logic              ln_we, ln_re;
  logic [IW-1:0]     ln_waddr, ln_raddr;
  logic [PW-1:0]     ln_wdata, ln_rdata;
  logic              dt_we, dt_re;
  logic [IW-1:0]     dt_waddr, dt_raddr;
  logic [SW-1:0]     dt_rdata;

  logic          accept;
  logic          out_free;
  logic [QW-1:0] q_in;
  logic [PW-1:0] head, tail;
  logic          head_nil;
  logic          free_nil;
  logic          virgin;
  logic          done;

  assign q_in     = queue_wrap(req_i.queue_id);
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  // pointers from the queue table, an unwritten queue reads as empty
  assign head     = qv_q ? qt_rdata[2*PW-1:PW] : NIL;
  assign tail     = qv_q ? qt_rdata[PW-1:0] : NIL;
  assign head_nil = (head >= NIL);
  assign free_nil = (free_head_q >= NIL);
  assign virgin   = (free_head_q == fill_q);

  assign req_i.ready = (state_q == S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (func_e'(req_i.func) == FUNC_ENQ) ? S_ENQ : S_DEQ_RD;
        end
      end
      S_ENQ: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DEQ_RD: begin
        if (!head_nil) begin
          state_d = S_DEQ_WB;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DEQ_WB: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // memory controls and register updates
  always_comb begin
    q_d         = q_q;
    data_d      = data_q;
    qv_d        = qv_q;
    free_head_d = free_head_q;
    fill_d      = fill_q;
    qvalid_d    = qvalid_q;
    qt_we       = 1'b0;
    qt_re       = 1'b0;
    qt_waddr    = q_q;
    qt_raddr    = q_in;
    qt_wdata    = {head, tail};
    ln_we       = 1'b0;
    ln_re       = 1'b0;
    ln_waddr    = tail[IW-1:0];
    ln_raddr    = free_head_q[IW-1:0];
    ln_wdata    = free_head_q;
    dt_we       = 1'b0;
    dt_re       = 1'b0;
    dt_waddr    = free_head_q[IW-1:0];
    dt_raddr    = head[IW-1:0];
    done        = 1'b0;
    out_data_d  = '0;
    out_status_d = STATUS_OK;

    unique case (state_q)
      S_IDLE: begin
        // look up the queue and the successor of the free-list head
        if (accept) begin
          q_d    = q_in;
          data_d = req_i.data_in[SW-1:0];
          qv_d   = qvalid_q[q_in];
          qt_re  = 1'b1;
          ln_re  = 1'b1;
        end
      end
      S_ENQ: begin
        if (out_free) begin
          done = 1'b1;
          if (free_nil) begin
            out_status_d = STATUS_OVERFLOW;
          end else begin
            // pop the free list, a never used slot links to its neighbor
            free_head_d = virgin ? PW'(free_head_q + 1'b1) : ln_rdata;
            fill_d      = virgin ? PW'(fill_q + 1'b1) : fill_q;
            dt_we       = 1'b1;
            ln_we       = !head_nil;
            ln_wdata    = free_head_q;
            qt_we       = 1'b1;
            qt_wdata    = {head_nil ? free_head_q : head, free_head_q};
            qvalid_d[q_q] = 1'b1;
          end
        end
      end
      S_DEQ_RD: begin
        if (!head_nil) begin
          // fetch link and data of the head slot
          ln_re    = 1'b1;
          ln_raddr = head[IW-1:0];
          dt_re    = 1'b1;
        end else if (out_free) begin
          done         = 1'b1;
          out_status_d = STATUS_UNDERFLOW;
        end
      end
      S_DEQ_WB: begin
        if (out_free) begin
          done        = 1'b1;
          // unlink the head, the last slot empties the queue
          qt_we       = 1'b1;
          qt_wdata    = {(head == tail) ? NIL : ln_rdata, tail};
          ln_we       = 1'b1;
          ln_waddr    = head[IW-1:0];
          ln_wdata    = free_head_q;
          free_head_d = head;
          out_data_d  = DATA_W'(dt_rdata);
        end
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      qvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      qvalid_q    <= qvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    data_q <= data_d;
    qv_q   <= qv_d;
    if (done) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.data_out = $signed(out_data_q);
  assign rsp_o.status   = out_status_q;

  // queue table: head and tail pointer per queue
  mqsb_ram #(
    .WIDTH (2 * PW),
    .DEPTH (QUEUES)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qt_we),
    .waddr_i (qt_waddr),
    .wdata_i (qt_wdata),
    .re_i    (qt_re),
    .raddr_i (qt_raddr),
    .rdata_o (qt_rdata)
  );

  // next-slot links
  mqsb_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (ln_waddr),
    .wdata_i (ln_wdata),
    .re_i    (ln_re),
    .raddr_i (ln_raddr),
    .rdata_o (ln_rdata)
  );

  // slot payload
  mqsb_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dt_we),
    .waddr_i (dt_waddr),
    .wdata_i (data_q),
    .re_i    (dt_re),
    .raddr_i (dt_raddr),
    .rdata_o (dt_rdata)
  );

endmodule
